// File: hdl/trsg_pkg.sv
// Shared constants for the tile region segment generator.
// Holds field widths, status codes, register indexes and default parameters.
// Depends on nothing.
package trsg_pkg;

    localparam int DEF_COORD_BITS = 24;
    localparam int DEF_MAX_LEVEL  = 12;

    localparam int TILE_DIM_BITS = 13;
    localparam int TILE_IDX_BITS = 12;
    localparam int LOD_BITS      = 4;
    localparam int NX_BITS       = TILE_DIM_BITS + (1 << LOD_BITS) - 1;
    localparam int CMP_BITS      = 34;
    localparam int STATUS_BITS   = 2;

    localparam logic [TILE_DIM_BITS-1:0] TILE_DIM_RESET = TILE_DIM_BITS'(256);

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BOUNDS    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_ACTIVE = 2'd2;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    localparam logic REG_TILE_WIDTH  = 1'b0;
    localparam logic REG_TILE_HEIGHT = 1'b1;

endpackage

// File: hdl/tile_region_segment_generator.sv
// Tile region segment generator: checks a start rectangle, then walks its tile segments.
// Uses trsg_pkg; one shared restoring divider serves all start-time divisions.
// Sequence: a start item is checked, then runs four serial divisions on the shared divider
// (one quotient bit per cycle), then finishes; a rejected start and a next item go
// straight to the result; a held result stalls the sequencer.
// Throughput: one item at a time; s_tready is low while an item is in work.
// Reset: synchronous active-low aresetn clears the sequencer, the output valid,
// the active request, and sets both tile sizes to 256.
module tile_region_segment_generator
    import trsg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_LEVEL  = DEF_MAX_LEVEL
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // left_x, top_y, right_x, bottom_y, detail_level, zero fill
    input  logic [((4*COORD_BITS+LOD_BITS+7)/8)*8-1:0] s_tdata,
    // action
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tile_col, tile_row, in_tile_x, in_tile_y, out_x, out_y, span_w, span_h, zero fill
    output logic [((4*TILE_IDX_BITS+4*COORD_BITS+2+7)/8)*8-1:0] m_tdata,
    // status
    output logic [STATUS_BITS-1:0] m_tuser,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CB     = COORD_BITS;
    localparam int SPW    = CB + 1;
    localparam int TCW    = MAX_LEVEL;
    localparam int CLW    = MAX_LEVEL + 2;
    localparam int CNTW   = $clog2(CB + 1);
    localparam int RW     = TILE_DIM_BITS + 1;
    localparam int OUT_W  = 4*TILE_IDX_BITS + 2*CB + 2*SPW;
    localparam int OUT_TW = ((OUT_W+7)/8)*8;

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_DIV_LOAD, S_DIV_RUN, S_START_FIN, S_NEXT
    } state_t;

    state_t state_reg;

    logic [TILE_DIM_BITS-1:0] tw_reg, th_reg;
    logic                     active_reg;

    logic [CB-1:0]       x0_reg, y0_reg, x1_reg, y1_reg;
    logic [LOD_BITS-1:0] lod_reg;

    logic [LOD_BITS-1:0] level_reg;
    logic [CB-1:0]       first_col_reg, end_col_reg, end_row_reg;
    logic [CB-1:0]       cur_x_reg, cur_y_reg, row_bound_reg, dest_x_reg, dest_y_reg;
    logic [SPW-1:0]      gw_reg;
    logic [TCW-1:0]      t0_reg, t1_reg, tile_col_reg, tile_row_reg, t_end_row_reg;
    logic [CLW-1:0]      cols_left_reg, cols_row_reg, rows_left_reg;
    logic [TILE_DIM_BITS-1:0] off0_reg, offx_reg, offy_reg;

    logic [1:0]          div_sel_reg;
    logic [CNTW-1:0]     div_cnt_reg;
    logic [CB-1:0]       div_quo_reg;
    logic [RW-1:0]       div_rem_reg;

    logic                    m_valid_reg, m_last_reg;
    logic [STATUS_BITS-1:0]  m_status_reg;
    logic [TILE_IDX_BITS-1:0] o_col_reg, o_row_reg, o_tx_reg, o_ty_reg;
    logic [CB-1:0]           o_x_reg, o_y_reg;
    logic [SPW-1:0]          o_w_reg, o_h_reg;

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    // start check
    logic [NX_BITS-1:0]  nx, ny;
    logic [CMP_BITS-1:0] nx_e, ny_e, lim_e, x0_e, y0_e, x1_e, y1_e, x1a_e, wd_e;
    logic                start_bad;
    always_comb begin
        nx    = NX_BITS'(tw_reg) << lod_reg;
        ny    = NX_BITS'(th_reg) << lod_reg;
        nx_e  = CMP_BITS'(nx);
        ny_e  = CMP_BITS'(ny);
        lim_e = CMP_BITS'(1) << CB;
        x0_e  = CMP_BITS'(x0_reg);
        y0_e  = CMP_BITS'(y0_reg);
        x1_e  = CMP_BITS'(x1_reg);
        y1_e  = CMP_BITS'(y1_reg);
        if (x0_reg == x1_reg) begin
            x1a_e = (x0_reg == '0) ? nx_e - 1'b1 : x1_e - 1'b1;
        end else begin
            x1a_e = x1_e;
        end
        wd_e = (x1a_e >= x0_e) ? x1a_e - x0_e + 1'b1 : nx_e - (x0_e - x1a_e - 1'b1);
        start_bad = (32'(lod_reg) > 32'(MAX_LEVEL)) || tw_reg == '0 || th_reg == '0
                 || nx_e > lim_e || ny_e > lim_e || x0_e >= nx_e || y0_e >= ny_e
                 || x1a_e >= nx_e || y1_e >= ny_e || y0_e > y1_e;
    end

    // shared divider step
    logic [TILE_DIM_BITS-1:0] div_divisor;
    logic [CB-1:0]            div_dividend;
    logic [RW-1:0]            div_shift;
    logic                     div_ge;
    logic [CB-1:0]            div_quo_new;
    logic [RW-1:0]            div_rem_new;
    always_comb begin
        div_divisor = div_sel_reg[1] ? th_reg : tw_reg;
        unique case (div_sel_reg)
            2'd0:    div_dividend = first_col_reg;
            2'd1:    div_dividend = end_col_reg;
            2'd2:    div_dividend = cur_y_reg;
            default: div_dividend = end_row_reg;
        endcase
        div_shift   = {div_rem_reg[RW-2:0], div_quo_reg[CB-1]};
        div_ge      = div_shift >= RW'(div_divisor);
        div_rem_new = div_ge ? div_shift - RW'(div_divisor) : div_shift;
        div_quo_new = {div_quo_reg[CB-2:0], div_ge};
    end

    // start finish and row setup
    logic           wraps;
    logic [CLW-1:0] cols_row_calc;
    logic [CB-1:0]  row_bound_start;
    always_comb begin
        wraps = end_col_reg < first_col_reg;
        if (wraps) begin
            cols_row_calc = (CLW'(1) << level_reg) - CLW'(t0_reg) + CLW'(t1_reg) + 1'b1;
        end else begin
            cols_row_calc = CLW'(t1_reg) - CLW'(t0_reg) + 1'b1;
        end
        row_bound_start = wraps ? CB'(gw_reg - 1'b1) : end_col_reg;
    end

    // segment step
    logic [SPW-1:0] seg_w, seg_h, avail_x, avail_y, tile_x, tile_y, sum_x;
    logic [TCW-1:0] col_mask;
    always_comb begin
        avail_x  = SPW'(row_bound_reg) - SPW'(cur_x_reg) + 1'b1;
        tile_x   = SPW'(tw_reg) - SPW'(offx_reg);
        seg_w    = (tile_x < avail_x) ? tile_x : avail_x;
        avail_y  = SPW'(end_row_reg) - SPW'(cur_y_reg) + 1'b1;
        tile_y   = SPW'(th_reg) - SPW'(offy_reg);
        seg_h    = (tile_y < avail_y) ? tile_y : avail_y;
        sum_x    = SPW'(cur_x_reg) + seg_w;
        col_mask = ~({TCW{1'b1}} << level_reg);
    end

    logic out_load;
    assign out_load = out_free && ((state_reg == S_CHECK && start_bad)
                                   || state_reg == S_START_FIN || state_reg == S_NEXT);

    logic cfg_wr;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_TILE_HEIGHT) ? 32'(th_reg) : 32'(tw_reg);
    assign s_tready = (state_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            active_reg  <= 1'b0;
            tw_reg      <= TILE_DIM_RESET;
            th_reg      <= TILE_DIM_RESET;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x0_reg     <= s_tdata[CB-1:0];
                        y0_reg     <= s_tdata[2*CB-1:CB];
                        x1_reg     <= s_tdata[3*CB-1:2*CB];
                        y1_reg     <= s_tdata[4*CB-1:3*CB];
                        lod_reg    <= s_tdata[4*CB+LOD_BITS-1:4*CB];
                        state_reg  <= (s_tuser == ACT_START) ? S_CHECK : S_NEXT;
                    end
                end
                S_CHECK: begin
                    if (start_bad) begin
                        if (out_free) begin
                            active_reg   <= 1'b0;
                            m_valid_reg  <= 1'b1;
                            m_status_reg <= ST_BOUNDS;
                            m_last_reg   <= 1'b0;
                            o_col_reg    <= '0;
                            o_row_reg    <= '0;
                            o_tx_reg     <= '0;
                            o_ty_reg     <= '0;
                            o_x_reg      <= '0;
                            o_y_reg      <= '0;
                            o_w_reg      <= '0;
                            o_h_reg      <= '0;
                            state_reg    <= S_IDLE;
                        end
                    end else begin
                        active_reg    <= 1'b0;
                        level_reg     <= lod_reg;
                        first_col_reg <= x0_reg;
                        end_col_reg   <= CB'(x1a_e);
                        end_row_reg   <= y1_reg;
                        cur_y_reg     <= y0_reg;
                        dest_y_reg    <= '0;
                        gw_reg        <= SPW'(nx);
                        div_sel_reg   <= 2'd0;
                        state_reg     <= S_DIV_LOAD;
                    end
                end
                S_DIV_LOAD: begin
                    div_quo_reg <= div_dividend;
                    div_rem_reg <= '0;
                    div_cnt_reg <= CNTW'(CB);
                    state_reg   <= S_DIV_RUN;
                end
                S_DIV_RUN: begin
                    div_quo_reg <= div_quo_new;
                    div_rem_reg <= div_rem_new;
                    div_cnt_reg <= div_cnt_reg - 1'b1;
                    if (div_cnt_reg == CNTW'(1)) begin
                        unique case (div_sel_reg)
                            2'd0: begin
                                t0_reg   <= TCW'(div_quo_new);
                                off0_reg <= TILE_DIM_BITS'(div_rem_new);
                            end
                            2'd1: t1_reg <= TCW'(div_quo_new);
                            2'd2: begin
                                tile_row_reg <= TCW'(div_quo_new);
                                offy_reg     <= TILE_DIM_BITS'(div_rem_new);
                            end
                            default: t_end_row_reg <= TCW'(div_quo_new);
                        endcase
                        div_sel_reg <= div_sel_reg + 1'b1;
                        state_reg   <= (div_sel_reg == 2'd3) ? S_START_FIN : S_DIV_LOAD;
                    end
                end
                S_START_FIN: begin
                    if (out_free) begin
                        rows_left_reg <= CLW'(t_end_row_reg) - CLW'(tile_row_reg) + 1'b1;
                        cols_row_reg  <= cols_row_calc;
                        cols_left_reg <= cols_row_calc;
                        cur_x_reg     <= first_col_reg;
                        dest_x_reg    <= '0;
                        tile_col_reg  <= t0_reg;
                        offx_reg      <= off0_reg;
                        row_bound_reg <= row_bound_start;
                        active_reg    <= 1'b1;
                        m_valid_reg   <= 1'b1;
                        m_status_reg  <= ST_OK;
                        m_last_reg    <= 1'b0;
                        o_col_reg     <= '0;
                        o_row_reg     <= '0;
                        o_tx_reg      <= '0;
                        o_ty_reg      <= '0;
                        o_x_reg       <= '0;
                        o_y_reg       <= '0;
                        o_w_reg       <= SPW'(wd_e);
                        o_h_reg       <= SPW'(y1_e - y0_e + 1'b1);
                        state_reg     <= S_IDLE;
                    end
                end
                S_NEXT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                        if (!active_reg) begin
                            m_status_reg <= ST_NO_ACTIVE;
                            m_last_reg   <= 1'b0;
                            o_col_reg    <= '0;
                            o_row_reg    <= '0;
                            o_tx_reg     <= '0;
                            o_ty_reg     <= '0;
                            o_x_reg      <= '0;
                            o_y_reg      <= '0;
                            o_w_reg      <= '0;
                            o_h_reg      <= '0;
                        end else begin
                            m_status_reg <= ST_OK;
                            o_col_reg    <= TILE_IDX_BITS'(tile_col_reg);
                            o_row_reg    <= TILE_IDX_BITS'(tile_row_reg);
                            o_tx_reg     <= TILE_IDX_BITS'(offx_reg);
                            o_ty_reg     <= TILE_IDX_BITS'(offy_reg);
                            o_x_reg      <= dest_x_reg;
                            o_y_reg      <= dest_y_reg;
                            o_w_reg      <= seg_w;
                            o_h_reg      <= seg_h;
                            if (cols_left_reg == CLW'(1) && rows_left_reg != CLW'(1)) begin
                                m_last_reg    <= 1'b0;
                                rows_left_reg <= rows_left_reg - 1'b1;
                                cur_y_reg     <= CB'(SPW'(cur_y_reg) + seg_h);
                                dest_y_reg    <= CB'(SPW'(dest_y_reg) + seg_h);
                                tile_row_reg  <= tile_row_reg + 1'b1;
                                offy_reg      <= '0;
                                cur_x_reg     <= first_col_reg;
                                dest_x_reg    <= '0;
                                tile_col_reg  <= t0_reg;
                                offx_reg      <= off0_reg;
                                row_bound_reg <= row_bound_start;
                                cols_left_reg <= cols_row_reg;
                            end else begin
                                m_last_reg    <= (cols_left_reg == CLW'(1));
                                dest_x_reg    <= CB'(SPW'(dest_x_reg) + seg_w);
                                offx_reg      <= '0;
                                if (sum_x >= gw_reg) begin
                                    cur_x_reg     <= '0;
                                    row_bound_reg <= end_col_reg;
                                end else begin
                                    cur_x_reg <= CB'(sum_x);
                                end
                                tile_col_reg  <= (tile_col_reg + 1'b1) & col_mask;
                                cols_left_reg <= cols_left_reg - 1'b1;
                                if (cols_left_reg == CLW'(1)) begin
                                    rows_left_reg <= rows_left_reg - 1'b1;
                                    active_reg    <= 1'b0;
                                end
                            end
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cfg_wr) begin
                active_reg <= 1'b0;
                if (paddr[2] == REG_TILE_WIDTH) begin
                    tw_reg <= pwdata[TILE_DIM_BITS-1:0];
                end else begin
                    th_reg <= pwdata[TILE_DIM_BITS-1:0];
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = OUT_TW'({o_h_reg, o_w_reg, o_y_reg, o_x_reg,
                               o_ty_reg, o_tx_reg, o_row_reg, o_col_reg});

endmodule
